### design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/psd_pkg.sv
// Package for the point to segment distance block: widths, codes, types, root step.
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DW = COORD_BITS + 1;     // coordinate difference
  localparam int PW = 2 * DW;             // product of two differences
  localparam int SW = PW + 1;             // sum of two products
  localparam int AW = 2 * SW + 6;         // root accumulators
  localparam int MW = 20;                 // root bits, one cell per bit
  localparam int BW = $clog2(MW);
  localparam int DIST_BITS = 17;
  localparam int DIR_BITS = 16;
  localparam int DIR_FRAC = 14;
  localparam int DIR_SHIFT = 2 * DIR_FRAC + 2;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [DIR_BITS-1:0] DIR_ONE = DIR_BITS'(1) << DIR_FRAC;
  localparam int OUT_BITS = DIST_BITS + 2 * DIR_BITS + 2;
  localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REGION_START    = 2'd0,
    REGION_END      = 2'd1,
    REGION_INTERIOR = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_END_X   = 2'd2,
    CFG_END_Y   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [AW-1:0] r;   // target, four times the square of the numerator
    logic [PW-1:0] d;   // denominator
    logic [AW-1:0] s;   // m*m*d
    logic [AW-1:0] t;   // m*d
    logic [MW-1:0] m;
  } root_lane_t;

  typedef struct packed {
    region_t region;
    logic    zero;
    logic    neg_x;
    logic    neg_y;
  } side_t;

  typedef struct packed {
    root_lane_t dist_root;
    root_lane_t dir_x;
    root_lane_t dir_y;
    side_t      side;
  } job_t;

  // One bit of m = floor(sqrt(r/d)), tried without multiplication.
  function automatic root_lane_t root_step(root_lane_t l, logic [BW-1:0] b);
    root_lane_t    o;
    logic [AW-1:0] trial;
    o = l;
    trial = l.s + ((l.t << 1) << b) + ((AW'(l.d) << b) << b);
    if (trial <= l.r) begin
      o.s = trial;
      o.t = l.t + (AW'(l.d) << b);
      o.m = l.m | (MW'(1) << b);
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### design/psd_front.sv
// Front stages: configuration, differences, products, region choice, root setup.
`default_nettype none
module psd_front import psd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [COORD_BITS-1:0] point_x,
  input  wire logic [COORD_BITS-1:0] point_y,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      job_t                  out_job
);

  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_X: start_x <= cfg_data;
        CFG_START_Y: start_y <= cfg_data;
        CFG_END_X:   end_x   <= cfg_data;
        CFG_END_Y:   end_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [DW-1:0] diff(logic [COORD_BITS-1:0] a,
                                                logic [COORD_BITS-1:0] b);
    return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  logic va, vb, vc, vd;
  logic adv_a, adv_b, adv_c, adv_d;

  assign adv_d = !vd || out_ready;
  assign adv_c = !vc || adv_d;
  assign adv_b = !vb || adv_c;
  assign adv_a = !va || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (adv_a) va <= in_valid;
      if (adv_b) vb <= va;
      if (adv_c) vc <= vb;
      if (adv_d) vd <= vc;
    end
  end

  // stage a: differences
  logic signed [DW-1:0] ux, uy, dx, dy, wx, wy;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      ux <= diff(point_x, start_x);
      uy <= diff(point_y, start_y);
      dx <= diff(end_x, start_x);
      dy <= diff(end_y, start_y);
      wx <= diff(point_x, end_x);
      wy <= diff(point_y, end_y);
    end
  end

  // stage b: products
  logic signed [PW-1:0] p_uxdx, p_uydy, p_dxuy, p_dyux;
  logic signed [PW-1:0] q_ux, q_uy, q_wx, q_wy, q_dx, q_dy;

  assign p_uxdx = ux * dx;
  assign p_uydy = uy * dy;
  assign p_dxuy = dx * uy;
  assign p_dyux = dy * ux;
  assign q_ux = ux * ux;
  assign q_uy = uy * uy;
  assign q_wx = wx * wx;
  assign q_wy = wy * wy;
  assign q_dx = dx * dx;
  assign q_dy = dy * dy;

  logic signed [SW-1:0] b_t, b_c;
  logic [PW-1:0]        b_len2, b_s0, b_s1;
  logic [PW-2:0]        b_ux2, b_uy2, b_wx2, b_wy2, b_dx2, b_dy2;
  logic                 b_ux_n, b_uy_n, b_wx_n, b_wy_n, b_dx_n, b_dy_p;

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_t    <= $signed({p_uxdx[PW-1], p_uxdx}) + $signed({p_uydy[PW-1], p_uydy});
      b_c    <= $signed({p_dxuy[PW-1], p_dxuy}) - $signed({p_dyux[PW-1], p_dyux});
      b_len2 <= {1'b0, q_dx[PW-2:0]} + {1'b0, q_dy[PW-2:0]};
      b_s0   <= {1'b0, q_ux[PW-2:0]} + {1'b0, q_uy[PW-2:0]};
      b_s1   <= {1'b0, q_wx[PW-2:0]} + {1'b0, q_wy[PW-2:0]};
      b_ux2  <= q_ux[PW-2:0];
      b_uy2  <= q_uy[PW-2:0];
      b_wx2  <= q_wx[PW-2:0];
      b_wy2  <= q_wy[PW-2:0];
      b_dx2  <= q_dx[PW-2:0];
      b_dy2  <= q_dy[PW-2:0];
      b_ux_n <= ux[DW-1];
      b_uy_n <= uy[DW-1];
      b_wx_n <= wx[DW-1];
      b_wy_n <= wy[DW-1];
      b_dx_n <= dx[DW-1];
      b_dy_p <= !dy[DW-1] && (dy != '0);
    end
  end

  // stage c: region, selection, partial products of c squared
  logic          in_int, past_end;
  logic [PW-1:0] cmag;
  logic [DW-1:0] c_hi, c_lo;
  logic [PW-1:0] sel_s;
  logic [PW-2:0] sel_x2, sel_y2;

  always_comb begin
    past_end = b_t > $signed({1'b0, b_len2});
    in_int   = (b_len2 != '0) && !b_t[SW-1] && !past_end;
    cmag     = b_c[SW-1] ? PW'(-b_c) : PW'(b_c);
    c_hi     = cmag[PW-1:DW];
    c_lo     = cmag[DW-1:0];
    if (b_len2 != '0 && past_end) begin
      sel_s  = b_s1;
      sel_x2 = b_wx2;
      sel_y2 = b_wy2;
    end else begin
      sel_s  = b_s0;
      sel_x2 = b_ux2;
      sel_y2 = b_uy2;
    end
  end

  logic          c_int;
  logic [PW-1:0] c_hh, c_hl, c_ll, c_s;
  root_lane_t    c_lx, c_ly;
  side_t         c_side;

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_int <= in_int;
      c_hh  <= c_hi * c_hi;
      c_hl  <= c_hi * c_lo;
      c_ll  <= c_lo * c_lo;
      c_s   <= sel_s;
      c_lx  <= '{r: in_int ? (AW'(b_dy2) << DIR_SHIFT) : (AW'(sel_x2) << DIR_SHIFT),
                 d: in_int ? b_len2 : sel_s, s: '0, t: '0, m: '0};
      c_ly  <= '{r: in_int ? (AW'(b_dx2) << DIR_SHIFT) : (AW'(sel_y2) << DIR_SHIFT),
                 d: in_int ? b_len2 : sel_s, s: '0, t: '0, m: '0};
      if (in_int) begin
        c_side <= '{region: REGION_INTERIOR, zero: (b_c == '0),
                    neg_x: b_dy_p != b_c[SW-1], neg_y: b_dx_n != b_c[SW-1]};
      end else if (b_len2 != '0 && past_end) begin
        c_side <= '{region: REGION_END, zero: (b_s1 == '0),
                    neg_x: b_wx_n, neg_y: b_wy_n};
      end else begin
        c_side <= '{region: REGION_START, zero: (b_s0 == '0),
                    neg_x: b_ux_n, neg_y: b_uy_n};
      end
    end
  end

  // stage d: distance target
  logic [AW-1:0] c_sq;
  assign c_sq = (AW'(c_hh) << (2 * DW)) + (AW'(c_hl) << (DW + 1)) + AW'(c_ll);

  always_ff @(posedge clk) begin
    if (adv_d) begin
      out_job.dist_root <= '{r: c_int ? (c_sq << 2) : (AW'(c_s) << 2),
                             d: c_int ? c_lx.d : PW'(1), s: '0, t: '0, m: '0};
      out_job.dir_x     <= c_lx;
      out_job.dir_y     <= c_ly;
      out_job.side      <= c_side;
    end
  end

  assign out_valid = vd;

endmodule
`default_nettype wire

### design/psd_root_cell.sv
// One cell of the root chain: decides one bit of each of the three roots.
`default_nettype none
module psd_root_cell import psd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [BW-1:0] bit_idx,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire job_t          in_job,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      job_t          out_job
);

  job_t job_next;

  always_comb begin
    job_next           = in_job;
    job_next.dist_root = root_step(in_job.dist_root, bit_idx);
    job_next.dir_x     = root_step(in_job.dir_x, bit_idx);
    job_next.dir_y     = root_step(in_job.dir_y, bit_idx);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_job <= job_next;
    end
  end

endmodule
`default_nettype wire

### design/psd_finish.sv
// Output stage: rounding, clamping, signs and the result register.
`default_nettype none
module psd_finish import psd_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire job_t                      in_job,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [OUT_BYTES_BITS-1:0] out_data
);

  logic [MW:0]           r_dist, r_x, r_y;
  logic [DIST_BITS-1:0]  dist_val;
  logic [DIR_BITS-1:0]   mag_x, mag_y, dir_x, dir_y;

  always_comb begin
    r_dist   = ({1'b0, in_job.dist_root.m} + (MW+1)'(1)) >> 1;
    r_x      = ({1'b0, in_job.dir_x.m} + (MW+1)'(1)) >> 1;
    r_y      = ({1'b0, in_job.dir_y.m} + (MW+1)'(1)) >> 1;
    dist_val = (r_dist > (MW+1)'(DIST_MAX)) ? DIST_MAX : r_dist[DIST_BITS-1:0];
    mag_x    = (r_x > (MW+1)'(DIR_ONE)) ? DIR_ONE : r_x[DIR_BITS-1:0];
    mag_y    = (r_y > (MW+1)'(DIR_ONE)) ? DIR_ONE : r_y[DIR_BITS-1:0];
    dir_x    = in_job.side.neg_x ? (~mag_x + DIR_BITS'(1)) : mag_x;
    dir_y    = in_job.side.neg_y ? (~mag_y + DIR_BITS'(1)) : mag_y;
    if (in_job.side.zero) begin
      dist_val = '0;
      dir_x    = '0;
      dir_y    = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= OUT_BYTES_BITS'({in_job.side.region, dir_y, dir_x, dist_val});
    end
  end

endmodule
`default_nettype wire

### design/point_segment_distance.sv
// Pipeline: 4 front stages, 20 root cells and 1 output register from input transaction to result;
// throughput one point per cycle while the output is not stalled, set by the cell chain.
// Each root cell decides one bit of the distance and both direction roots.
// A stalled output holds the chain stage by stage; new points are taken while bubbles remain.
// Reset (rst, synchronous) clears all valid flags and the segment endpoints to zero.
`default_nettype none
module point_segment_distance import psd_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [COORD_BITS-1:0]     cfg_data,
  input  wire logic                      s_axis_tvalid,
  output      logic                      s_axis_tready,
  input  wire logic [2*COORD_BITS-1:0]   s_axis_tdata,  // point_x, point_y
  output      logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output      logic [OUT_BYTES_BITS-1:0] m_axis_tdata   // distance, dir_x, dir_y, region, pad
);

  logic       v   [MW+1];
  logic       rdy [MW+1];
  job_t       job [MW+1];

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .point_x   (s_axis_tdata[COORD_BITS-1:0]),
    .point_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_valid (v[0]),
    .out_ready (rdy[0]),
    .out_job   (job[0])
  );

  for (genvar i = 0; i < MW; i++) begin : g_cell
    psd_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bit_idx   (BW'(MW - 1 - i)),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .in_job    (job[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .out_job   (job[i+1])
    );
  end

  psd_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[MW]),
    .in_ready  (rdy[MW]),
    .in_job    (job[MW]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

### design/psd_checker.sv
// Port-level checker for point_segment_distance, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module psd_checker import psd_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [OUT_BYTES_BITS-1:0] m_axis_tdata
);

  logic [DIST_BITS-1:0]       dist_val;
  logic signed [DIR_BITS-1:0] dx, dy;
  region_t                    rg;
  logic                       dir_ok;
  logic                       rg_ok;

  assign dist_val = m_axis_tdata[DIST_BITS-1:0];
  assign dx       = m_axis_tdata[DIST_BITS+DIR_BITS-1:DIST_BITS];
  assign dy       = m_axis_tdata[DIST_BITS+2*DIR_BITS-1:DIST_BITS+DIR_BITS];
  assign rg       = region_t'(m_axis_tdata[DIST_BITS+2*DIR_BITS+1:DIST_BITS+2*DIR_BITS]);
  assign dir_ok   = dx <= $signed(DIR_ONE) && dx >= -$signed(DIR_ONE) &&
                    dy <= $signed(DIR_ONE) && dy >= -$signed(DIR_ONE);
  assign rg_ok    = rg == REGION_START || rg == REGION_END || rg == REGION_INTERIOR;

  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_IMPLY(a_region, clk, rst, m_axis_tvalid, rg_ok)
  `ASSERT_IMPLY(a_nonzero_dir, clk, rst, m_axis_tvalid && dist_val != '0, dx != '0 || dy != '0)
  `ASSERT_IMPLY(a_unit_range, clk, rst, m_axis_tvalid, dir_ok)

endmodule

bind point_segment_distance psd_checker u_psd_checker (.*);
`default_nettype wire

### verif/tb_point_segment_distance.sv
// Self-checking testbench for point_segment_distance: queued point transactions, predicted results.
`default_nettype none
module tb_point_segment_distance;
  import psd_pkg::*;

  typedef struct packed {
    logic [15:0] py;
    logic [15:0] px;
  } point_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic [DIR_BITS-1:0]  dir_x;
    logic [DIR_BITS-1:0]  dir_y;
    region_t              region;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_START_X;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2*COORD_BITS-1:0] s_axis_tdata = '0;  // point_x, point_y
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_BYTES_BITS-1:0] m_axis_tdata;     // distance, dir_x, dir_y, region, pad

  point_t      pending_points[$];
  seg_result_t expected_results[$];
  logic [15:0] seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
  int unsigned send_idle = 0, recv_idle = 0;
  int errors = 0;
  int checked = 0;
  logic hold_go = 1'b0;
  int unsigned hold_cnt = 0;

  point_segment_distance dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(8 * 400000);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] root_ratio(logic [63:0] p, logic [63:0] q,
                                             logic [63:0] den, logic [63:0] cap);
    logic [127:0] n;
    logic [127:0] trial;
    logic [63:0] m;
    logic [63:0] c;
    logic [63:0] r;
    n = ({64'd0, p} * {64'd0, q}) << 2;
    m = 0;
    for (int b = 19; b >= 0; b--) begin
      c = m | (64'd1 << b);
      trial = {64'd0, c * c} * {64'd0, den};
      if (trial <= n) m = c;
    end
    r = (m + 1) >> 1;
    return (r > cap) ? cap : r;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [15:0] unit_component(longint num, logic neg, logic [63:0] den);
    logic [63:0] a;
    logic [63:0] r;
    a = magnitude(num) * 64'd16384;
    r = root_ratio(a, a, den, 64'd16384);
    return ((num < 0) != neg) ? 16'(-r) : 16'(r);
  endfunction

  function automatic seg_result_t nearest_point_result(point_t pt);
    seg_result_t res;
    longint px, py, sx, sy, ex, ey, ux, uy, dx, dy, dot, len2, vx, vy, sq, cr;
    px = longint'($signed(pt.px));
    py = longint'($signed(pt.py));
    sx = longint'($signed(seg_sx));
    sy = longint'($signed(seg_sy));
    ex = longint'($signed(seg_ex));
    ey = longint'($signed(seg_ey));
    ux = px - sx;
    uy = py - sy;
    dx = ex - sx;
    dy = ey - sy;
    dot = ux * dx + uy * dy;
    len2 = dx * dx + dy * dy;
    res = '0;
    if (len2 == 0 || dot < 0 || dot > len2) begin
      vx = ux;
      vy = uy;
      res.region = REGION_START;
      if (len2 != 0 && dot > len2) begin
        vx = px - ex;
        vy = py - ey;
        res.region = REGION_END;
      end
      sq = vx * vx + vy * vy;
      if (sq != 0) begin
        res.distance = DIST_BITS'(root_ratio(64'(sq), 64'd1, 64'd1, 64'(DIST_MAX)));
        res.dir_x = unit_component(vx, 1'b0, 64'(sq));
        res.dir_y = unit_component(vy, 1'b0, 64'(sq));
      end
    end else begin
      res.region = REGION_INTERIOR;
      cr = dx * uy - dy * ux;
      if (cr != 0) begin
        res.distance = DIST_BITS'(root_ratio(magnitude(cr), magnitude(cr), 64'(len2),
                                             64'(DIST_MAX)));
        res.dir_x = unit_component(-dy, cr < 0, 64'(len2));
        res.dir_y = unit_component(dx, cr < 0, 64'(len2));
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(nearest_point_result(pending_points[0]));
        pending_points.pop_front();
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (pending_points.size() != 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_points[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt <= 400;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          if (m_axis_tdata[16:0] !== expected_results[0].distance)
            report_mismatch("distance", m_axis_tdata[16:0], expected_results[0].distance);
          if (m_axis_tdata[32:17] !== expected_results[0].dir_x)
            report_mismatch("dir_x", $signed(m_axis_tdata[32:17]),
                            $signed(expected_results[0].dir_x));
          if (m_axis_tdata[48:33] !== expected_results[0].dir_y)
            report_mismatch("dir_y", $signed(m_axis_tdata[48:33]),
                            $signed(expected_results[0].dir_y));
          if (m_axis_tdata[50:49] !== expected_results[0].region)
            report_mismatch("region", m_axis_tdata[50:49], expected_results[0].region);
          expected_results.pop_front();
          checked++;
        end
      end
      m_axis_tready <= (hold_cnt == 0) && !hold_go && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_X: seg_sx = value;
      CFG_START_Y: seg_sy = value;
      CFG_END_X:   seg_ex = value;
      default:     seg_ey = value;
    endcase
  endtask

  task automatic set_segment(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                             logic [15:0] ey);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_END_X, ex);
    write_reg(CFG_END_Y, ey);
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_point(logic [15:0] x, logic [15:0] y);
    point_t pt;
    pt.px = x;
    pt.py = y;
    pending_points.push_back(pt);
  endtask

  // mostly points near the segment, some anywhere in the plane
  task automatic add_random_points(int count);
    int unsigned kind;
    logic [15:0] dx, dy;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      dx = seg_ex - seg_sx;
      dy = seg_ey - seg_sy;
      case (kind)
        0, 1, 2: add_point(16'($urandom), 16'($urandom));
        3: add_point(seg_sx + 16'($urandom_range(64)) - 16'd32,
                     seg_sy + 16'($urandom_range(64)) - 16'd32);
        4: add_point(seg_ex + 16'($urandom_range(64)) - 16'd32,
                     seg_ey + 16'($urandom_range(64)) - 16'd32);
        5: add_point(seg_sx + {dx[15], dx[15:1]}, seg_sy + {dy[15], dy[15:1]});
        default: add_point(seg_sx + {dx[15], dx[15:1]} + 16'($urandom_range(2048)) - 16'd1024,
                           seg_sy + {dy[15], dy[15:1]} + 16'($urandom_range(2048)) - 16'd1024);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: zero-length segment at origin, one query on it and one off it
    add_point(16'h0000, 16'h0000);
    add_point(16'h0100, 16'h0000);
    drain();

    set_segment(16'hFF00, 16'h0000, 16'h0100, 16'h0000);
    add_point(16'hFF00, 16'h0000);  // on start
    add_point(16'h0100, 16'h0000);  // on end
    add_point(16'h0000, 16'h0000);  // interior, on segment
    add_point(16'h0000, 16'h0200);
    add_point(16'h0000, 16'hFE00);
    add_point(16'hFE00, 16'h0100);
    add_point(16'h0300, 16'hFF00);
    add_point(16'hFEFF, 16'h0000);
    add_point(16'h0101, 16'h0000);
    add_point(16'h8000, 16'h8000);
    add_point(16'h7FFF, 16'h7FFF);
    add_point(16'h8000, 16'h7FFF);
    add_point(16'h7FFF, 16'h8000);
    add_point(16'hFFFF, 16'hFFFF);
    add_point(16'h5555, 16'hAAAA);
    add_point(16'h0000, 16'h0001);
    drain();

    send_idle = 53;
    set_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    add_point(16'h8000, 16'h7FFF);
    add_point(16'h7FFF, 16'h8000);
    add_random_points(80);
    drain();

    send_idle = 0;
    recv_idle = 53;
    set_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    add_random_points(100);
    repeat (30) @(posedge clk);
    @(posedge clk) hold_go <= 1'b1;
    @(posedge clk) hold_go <= 1'b0;
    drain();

    send_idle = 38;
    recv_idle = 38;
    set_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    add_random_points(80);
    drain();

    set_segment(16'h1234, 16'hF000, 16'h1234, 16'hF000);
    add_point(16'h1234, 16'hF000);
    add_random_points(40);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_segment(16'h0000, 16'h0100, 16'h0000, 16'hFF00);
    add_random_points(100);
    drain();

    $display("checked %0d results over 7 segment settings, including zero-length,",
             checked);
    $display("full-range diagonals and idle/stall mixes with a long output hold");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### point_segment_distance.f
+incdir+design
design/psd_pkg.sv
design/psd_front.sv
design/psd_root_cell.sv
design/psd_finish.sv
design/point_segment_distance.sv
design/psd_checker.sv
verif/tb_point_segment_distance.sv
